// ----- rtl/core/fda_pkg.sv -----
// ----------------------------------------------------------------------------
// fda_pkg
// Shared constants and types for the fixed-point to decimal text converter.
// ----------------------------------------------------------------------------
package fda_pkg;

  localparam int FRAC_BITS = 8;
  localparam int VAL_W     = 32;
  localparam int IPART_W   = VAL_W - FRAC_BITS;
  localparam int NDIG      = 10;
  localparam int BCD_W     = 4 * NDIG;
  localparam int CNT_W     = $clog2(IPART_W + 1);
  localparam int DIGC_W    = $clog2(NDIG + 1);
  localparam int PROD_W    = FRAC_BITS + 7;
  localparam int CHAR_W    = 7;

  localparam logic [CHAR_W-1:0] CH_MINUS = 7'd45;
  localparam logic [CHAR_W-1:0] CH_DOT   = 7'd46;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'd48;

  typedef struct packed {
    logic       carry;
    logic [3:0] tens;
    logic [3:0] ones;
  } fda_hund_t;

  typedef struct packed {
    logic start;
    logic next_digit;
  } fda_bcd_cmd_t;

endpackage

// ----- rtl/core/fda_round.sv -----
// ----------------------------------------------------------------------------
// fda_round
// Rounds the fraction half-up to hundredths and splits it into two digits.
// ----------------------------------------------------------------------------
module fda_round (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [fda_pkg::FRAC_BITS-1:0] frac,
  output logic                          hund_valid,
  output fda_pkg::fda_hund_t            hund
);
  import fda_pkg::*;

  logic [PROD_W-1:0] prod_r;
  logic [6:0]        hf_r;
  logic              carry_r;
  logic              v1_r, v2_r, v3_r;
  logic [6:0]        h;
  logic [14:0]       q;
  logic [3:0]        tens;
  logic [6:0]        ones_w;
  fda_hund_t         hund_r;

  assign h      = prod_r[PROD_W-1:FRAC_BITS];
  assign q      = 15'(hf_r) * 15'd205;
  assign tens   = q[14:11];
  assign ones_w = hf_r - {tens, 3'b000} - {2'b00, tens, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= PROD_W'(frac) * PROD_W'(100) + (PROD_W'(1) << (FRAC_BITS - 1));
    end
    if (v1_r) begin
      carry_r <= (h == 7'd100);
      hf_r    <= (h == 7'd100) ? 7'd0 : h;
    end
    if (v2_r) begin
      hund_r.carry <= carry_r;
      hund_r.tens  <= tens;
      hund_r.ones  <= ones_w[3:0];
    end
  end

  assign hund_valid = v3_r;
  assign hund       = hund_r;

endmodule

// ----- rtl/core/fda_bcd.sv -----
// ----------------------------------------------------------------------------
// fda_bcd
// Bit-serial binary to BCD conversion by shift and add-three, then a digit
// shift register that hands out the most significant digit first.
// ----------------------------------------------------------------------------
module fda_bcd (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fda_pkg::fda_bcd_cmd_t       cmd,
  input  logic [fda_pkg::IPART_W-1:0] bin,
  output logic                        done,
  output logic [3:0]                  top_digit
);
  import fda_pkg::*;

  logic [IPART_W-1:0] sr_r;
  logic [BCD_W-1:0]   bcd_r;
  logic [BCD_W-1:0]   adj;
  logic [CNT_W-1:0]   cnt_r;
  logic               run_r;

  function automatic logic digits_ok(input logic [BCD_W-1:0] b);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < NDIG; i++) begin
      if (b[4*i +: 4] > 4'd9) ok = 1'b0;
    end
    return ok;
  endfunction

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3 : bcd_r[4*i +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else if (cmd.start) begin
      run_r <= 1'b1;
    end else if (run_r && cnt_r == CNT_W'(1)) begin
      run_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      sr_r  <= bin;
      bcd_r <= '0;
      cnt_r <= CNT_W'(IPART_W);
    end else if (run_r) begin
      bcd_r <= {adj[BCD_W-2:0], sr_r[IPART_W-1]};
      sr_r  <= {sr_r[IPART_W-2:0], 1'b0};
      cnt_r <= cnt_r - CNT_W'(1);
    end else if (cmd.next_digit) begin
      bcd_r <= {bcd_r[BCD_W-5:0], 4'd0};
    end
  end

  assign done      = !run_r;
  assign top_digit = bcd_r[BCD_W-1 -: 4];

  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> run_r)
    else $error("conversion did not start");

  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (run_r && !cmd.start && cnt_r == CNT_W'(1)) |=> !run_r)
    else $error("conversion ran past its bit count");

  a_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (run_r && !cmd.start) |=> digits_ok(bcd_r))
    else $error("BCD digit out of range");

endmodule

// ----- rtl/core/fixed_to_decimal_ascii_core.sv -----
// ----------------------------------------------------------------------------
// fixed_to_decimal_ascii_core
// Converts one signed fixed-point number (FRAC_BITS fraction bits) into its
// decimal text, one ASCII character per output item: an optional '-', the
// integer digits without leading zeros, '.', and two fraction digits rounded
// half-up. The last character of each number carries out_last_char. One
// number is handled at a time: a new input is taken only once the last
// character of the previous number has been emitted. The integer part is
// converted by a bit-serial BCD conversion, then leading zero digits are
// skipped one position at a time before the characters are emitted.
// ----------------------------------------------------------------------------
module fixed_to_decimal_ascii_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [fda_pkg::VAL_W-1:0] in_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [fda_pkg::CHAR_W-1:0]  out_char_code,
  output logic                        out_last_char
);
  import fda_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_MAG    = 12'b0000_0000_0010,
    S_RSTART = 12'b0000_0000_0100,
    S_RWAIT  = 12'b0000_0000_1000,
    S_BSTART = 12'b0000_0001_0000,
    S_CONV   = 12'b0000_0010_0000,
    S_SKIP   = 12'b0000_0100_0000,
    S_SIGN   = 12'b0000_1000_0000,
    S_INT    = 12'b0001_0000_0000,
    S_DOT    = 12'b0010_0000_0000,
    S_TENS   = 12'b0100_0000_0000,
    S_ONES   = 12'b1000_0000_0000
  } state_t;

  state_t            state_r, state_nxt;
  logic [VAL_W-1:0]  val_r;
  logic [VAL_W-1:0]  mag_r;
  logic              neg_r;
  logic [DIGC_W-1:0] dig_left_r, dig_left_nxt;
  logic              out_valid_r;
  logic [CHAR_W-1:0] out_char_r;
  logic              out_last_r;
  logic              out_free;
  logic              emit;
  logic [CHAR_W-1:0] emit_char;
  logic              emit_last;
  logic              round_start;
  logic              hund_valid;
  fda_hund_t         hund;
  fda_bcd_cmd_t      bcd_cmd;
  logic              bcd_done;
  logic [3:0]        top_digit;
  logic [IPART_W-1:0] ipart_ld;

  fda_round u_round (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (round_start),
    .frac       (mag_r[FRAC_BITS-1:0]),
    .hund_valid (hund_valid),
    .hund       (hund)
  );

  assign ipart_ld = mag_r[VAL_W-1:FRAC_BITS] + IPART_W'(hund.carry);

  fda_bcd u_bcd (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (bcd_cmd),
    .bin       (ipart_ld),
    .done      (bcd_done),
    .top_digit (top_digit)
  );

  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt    = state_r;
    dig_left_nxt = dig_left_r;
    bcd_cmd      = '0;
    round_start  = 1'b0;
    emit         = 1'b0;
    emit_char    = CH_ZERO;
    emit_last    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_MAG;
      end
      S_MAG: begin
        state_nxt = S_RSTART;
      end
      S_RSTART: begin
        round_start = 1'b1;
        state_nxt   = S_RWAIT;
      end
      S_RWAIT: begin
        if (hund_valid) state_nxt = S_BSTART;
      end
      S_BSTART: begin
        bcd_cmd.start = 1'b1;
        dig_left_nxt  = DIGC_W'(NDIG);
        state_nxt     = S_CONV;
      end
      S_CONV: begin
        if (bcd_done) state_nxt = S_SKIP;
      end
      S_SKIP: begin
        if (top_digit == 4'd0 && dig_left_r > DIGC_W'(1)) begin
          bcd_cmd.next_digit = 1'b1;
          dig_left_nxt       = dig_left_r - DIGC_W'(1);
        end else begin
          state_nxt = neg_r ? S_SIGN : S_INT;
        end
      end
      S_SIGN: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = CH_MINUS;
          state_nxt = S_INT;
        end
      end
      S_INT: begin
        if (out_free) begin
          emit               = 1'b1;
          emit_char          = CH_ZERO + {3'b000, top_digit};
          bcd_cmd.next_digit = 1'b1;
          dig_left_nxt       = dig_left_r - DIGC_W'(1);
          if (dig_left_r == DIGC_W'(1)) state_nxt = S_DOT;
        end
      end
      S_DOT: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = CH_DOT;
          state_nxt = S_TENS;
        end
      end
      S_TENS: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = CH_ZERO + {3'b000, hund.tens};
          state_nxt = S_ONES;
        end
      end
      S_ONES: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = CH_ZERO + {3'b000, hund.ones};
          emit_last = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    dig_left_r <= dig_left_nxt;
    if (in_valid && !in_stall) begin
      val_r <= in_value;
    end
    if (state_r == S_MAG) begin
      neg_r <= val_r[VAL_W-1];
      mag_r <= val_r[VAL_W-1] ? (~val_r + VAL_W'(1)) : val_r;
    end
    if (emit) begin
      out_char_r <= emit_char;
      out_last_r <= emit_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last_char = out_last_r;

  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_MAG))
    else $error("accepted item did not start conversion");

  a_int_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INT) |-> (dig_left_r != '0))
    else $error("integer digit emitted with no digits left");

  a_round_wait: assert property (@(posedge clk) disable iff (!rst_n)
    hund_valid |-> (state_r == S_RWAIT))
    else $error("rounding result arrived outside its wait state");

endmodule
